// ----- hdl/stid_pkg.sv -----
// ----------------------------------------------------------------------------
// stid_pkg
// Shared types and codes of the sorted table core: request kinds, result
// status codes, controller states and the command and status structs that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package stid_pkg;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_ABSENT = 2'd1;
    localparam logic [1:0] STAT_EMPTY  = 2'd2;
    localparam logic [1:0] STAT_FULL   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_WALK,
        ST_SCAN,
        ST_DEL_SHIFT,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_INS_START,
        DP_INS_SHIFT,
        DP_INS_PLACE,
        DP_SCAN_START,
        DP_SCAN_NEXT,
        DP_DEL_SHIFT,
        DP_DEL_DONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       capture;
        logic       load_out;
        logic [1:0] out_status;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic at_end;
        logic at_zero;
        logic lt;
        logic eq;
    } dp_stat_t;

endpackage

// ----- hdl/stid_datapath.sv -----
// ----------------------------------------------------------------------------
// stid_datapath
// Table memory, entry count, walk index, captured value, comparator and the
// result register. It carries out one command from the controller each cycle.
// ----------------------------------------------------------------------------
module stid_datapath
    import stid_pkg::*;
#(
    parameter int CAPACITY   = 32,
    parameter int VALUE_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [31:0] item_value,
    output dp_stat_t    stat,
    output logic [1:0]  status,
    output logic [5:0]  entry_total
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);

    logic [VALUE_BITS-1:0] mem [CAPACITY];

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      idx_next;
    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] rdata_reg;
    logic [1:0]            status_out_reg;
    logic [5:0]            total_out_reg;

    logic [CNT_W-1:0]       rd_idx;
    logic                   wr_en;
    logic [CNT_W-1:0]       wr_idx;
    logic [VALUE_BITS-1:0]  wr_data;
    logic [VALUE_BITS+31:0] val_ext;
    logic [CNT_W+5:0]       cnt_ext;

    assign val_ext = {{VALUE_BITS{1'b0}}, item_value};
    assign cnt_ext = {6'd0, count_reg};

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        rd_idx     = idx_reg;
        wr_en      = 1'b0;
        wr_idx     = idx_reg;
        wr_data    = rdata_reg;
        unique case (cmd.op)
            DP_INS_START:
            begin
                idx_next = count_reg;
                rd_idx   = count_reg - CNT_W'(1);
            end
            DP_INS_SHIFT:
            begin
                wr_en    = 1'b1;
                idx_next = idx_reg - CNT_W'(1);
                rd_idx   = idx_reg - CNT_W'(2);
            end
            DP_INS_PLACE:
            begin
                wr_en      = 1'b1;
                wr_data    = val_reg;
                count_next = count_reg + CNT_W'(1);
            end
            DP_SCAN_START:
            begin
                idx_next = '0;
                rd_idx   = '0;
            end
            DP_SCAN_NEXT:
            begin
                idx_next = idx_reg + CNT_W'(1);
                rd_idx   = idx_reg + CNT_W'(1);
            end
            DP_DEL_SHIFT:
            begin
                wr_en    = 1'b1;
                wr_idx   = idx_reg - CNT_W'(1);
                idx_next = idx_reg + CNT_W'(1);
                rd_idx   = idx_reg + CNT_W'(1);
            end
            DP_DEL_DONE:
            begin
                count_next = count_reg - CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx[AW-1:0]] <= wr_data;
        end
        rdata_reg <= mem[rd_idx[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            val_reg <= val_ext[VALUE_BITS-1:0];
        end
        if (cmd.load_out)
        begin
            status_out_reg <= cmd.out_status;
            total_out_reg  <= cnt_ext[5:0];
        end
    end

    assign stat.full    = (count_reg == CNT_W'(CAPACITY));
    assign stat.empty   = (count_reg == '0);
    assign stat.at_end  = (idx_reg == count_reg);
    assign stat.at_zero = (idx_reg == '0);
    assign stat.lt      = (rdata_reg < val_reg);
    assign stat.eq      = (rdata_reg == val_reg);

    assign status      = status_out_reg;
    assign entry_total = total_out_reg;

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("Entry count exceeds the capacity.");

    a_place_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_INS_PLACE |-> !stat.full)
        else $error("An entry was placed into a full table.");

    a_remove_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_DEL_DONE |-> !stat.empty)
        else $error("An entry was removed from an empty table.");

    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_SCAN_NEXT || cmd.op == DP_DEL_SHIFT) |-> idx_reg < count_reg)
        else $error("The walk index passed the entry count.");
`endif

endmodule

// ----- hdl/stid_ctrl.sv -----
// ----------------------------------------------------------------------------
// stid_ctrl
// Controller of the sorted table core. It takes requests, steps the datapath
// through the insert walk, the search scan and the delete shift, and hands
// the result to the output register.
// ----------------------------------------------------------------------------
module stid_ctrl
    import stid_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] kind,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd
);

    state_t     state_reg;
    state_t     state_next;
    logic       is_del_reg;
    logic       is_del_next;
    logic [1:0] res_reg;
    logic [1:0] res_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next  = state_reg;
        is_del_next = is_del_reg;
        res_next    = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (kind)
                        KIND_INSERT:
                        begin
                            if (stat.full)
                            begin
                                res_next   = STAT_FULL;
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                state_next = ST_INS_WALK;
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (stat.empty)
                            begin
                                res_next   = STAT_EMPTY;
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                is_del_next = 1'b1;
                                state_next  = ST_SCAN;
                            end
                        end
                        KIND_SEARCH:
                        begin
                            is_del_next = 1'b0;
                            state_next  = ST_SCAN;
                        end
                        default:
                        begin
                            res_next   = STAT_OK;
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_INS_WALK:
            begin
                if (stat.at_zero || stat.lt)
                begin
                    res_next   = STAT_OK;
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (stat.at_end || (!stat.lt && !stat.eq))
                begin
                    res_next   = STAT_ABSENT;
                    state_next = ST_FINISH;
                end
                else if (stat.eq)
                begin
                    res_next   = STAT_OK;
                    state_next = is_del_reg ? ST_DEL_SHIFT : ST_FINISH;
                end
            end
            ST_DEL_SHIFT:
            begin
                if (stat.at_end)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '{op: DP_NOP, capture: 1'b0, load_out: 1'b0, out_status: res_reg};
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    if (kind == KIND_INSERT && !stat.full)
                    begin
                        cmd.op = DP_INS_START;
                    end
                    else if ((kind == KIND_DELETE && !stat.empty) || kind == KIND_SEARCH)
                    begin
                        cmd.op = DP_SCAN_START;
                    end
                end
            end
            ST_INS_WALK:
            begin
                cmd.op = (stat.at_zero || stat.lt) ? DP_INS_PLACE : DP_INS_SHIFT;
            end
            ST_SCAN:
            begin
                if (!stat.at_end && (stat.lt || (stat.eq && is_del_reg)))
                begin
                    cmd.op = DP_SCAN_NEXT;
                end
            end
            ST_DEL_SHIFT:
            begin
                cmd.op = stat.at_end ? DP_DEL_DONE : DP_DEL_SHIFT;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            is_del_reg    <= 1'b0;
            res_reg       <= STAT_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            is_del_reg    <= is_del_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && slot_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("A finished request did not reach the output register.");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid) |=> state_reg != ST_IDLE)
        else $error("An accepted request was dropped.");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("A stalled result was dropped.");
`endif

endmodule

// ----- hdl/sorted_table_insert_delete_search_core.sv -----
// ----------------------------------------------------------------------------
// sorted_table_insert_delete_search_core
// Keeps up to CAPACITY unsigned values in ascending order and serves insert,
// delete and search requests, each returning a status and the entry count.
//
//   Channel   Direction  Handshake            Fields
//   in        input      in_valid/in_stall    kind, item_value
//   out       output     out_valid/out_stall  status, entry_total
//
// An insert walks down from the top entry with one memory read and write per
// cycle. A delete and a search walk up from the bottom entry, and a delete then
// shifts the entries above the match down. Refused or ignored requests go
// straight to the finish state.
// Reset clears the entry count; the table memory is not cleared.
// A new item is accepted while a result waits in the output register.
// ----------------------------------------------------------------------------
module sorted_table_insert_delete_search_core
    import stid_pkg::*;
#(
    parameter int CAPACITY   = 32,
    parameter int VALUE_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] item_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [5:0]  entry_total
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    stid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    stid_datapath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .item_value  (item_value),
        .stat        (stat),
        .status      (status),
        .entry_total (entry_total)
    );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking testbench for the sorted table core. A short table of
// directed requests covers the empty case, the extreme values,
// duplicates and the unused kind. Random fill, drain and mixed request
// sequences follow. Every result is checked against a behavioral model of the
// table while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import stid_pkg::*;

    localparam int         CAPACITY      = 32;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam int         DIRECTED_ROWS = 25;
    localparam int         RANDOM_ITEMS  = 360;
    localparam int         HOLD_AT       = 100;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         DRAIN_CYCLES  = 40;
    localparam int         IDLE_LIMIT    = 4000;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] total;
    } table_result_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic        known;
        logic [1:0]  status;
        logic [5:0]  total;
    } request_row_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic [1:0]  kind       = KIND_SEARCH;
    logic [31:0] item_value = '0;
    logic        out_stall  = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [1:0]  status;
    logic [5:0]  entry_total;

    logic [31:0]   table_mem [CAPACITY];
    int unsigned   table_count = 0;
    table_result_t pending_results [$];
    request_row_t  directed_rows [DIRECTED_ROWS];

    int error_count    = 0;
    int accepted_items = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    bit calm           = 1'b0;

    sorted_table_insert_delete_search_core u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .entry_total (entry_total)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic table_result_t apply_table_request(logic [1:0] k, logic [31:0] v);
        table_result_t r;
        int unsigned   pos;
        int unsigned   j;
        r.status = STAT_OK;
        pos = 0;
        while (pos < table_count && table_mem[pos] < v)
            pos++;
        case (k)
            KIND_INSERT:
            begin
                if (table_count >= CAPACITY)
                    r.status = STAT_FULL;
                else
                begin
                    for (j = table_count; j > pos; j--)
                        table_mem[j] = table_mem[j - 1];
                    table_mem[pos] = v;
                    table_count++;
                end
            end
            KIND_DELETE:
            begin
                if (table_count == 0)
                    r.status = STAT_EMPTY;
                else if (pos < table_count && table_mem[pos] == v)
                begin
                    for (j = pos; j + 1 < table_count; j++)
                        table_mem[j] = table_mem[j + 1];
                    table_count--;
                end
                else
                    r.status = STAT_ABSENT;
            end
            KIND_SEARCH:
            begin
                if (!(pos < table_count && table_mem[pos] == v))
                    r.status = STAT_ABSENT;
            end
            default:
            begin
            end
        endcase
        r.total = table_count[5:0];
        return r;
    endfunction

    function automatic logic [1:0] pick_kind(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return KIND_UNUSED;
        case (mode)
            0:       return (r < 80) ? KIND_INSERT : (r < 90) ? KIND_SEARCH : KIND_DELETE;
            1, 2:    return (r < 10) ? KIND_INSERT : (r < 88) ? KIND_DELETE : KIND_SEARCH;
            default: return (r < 37) ? KIND_INSERT : (r < 68) ? KIND_DELETE : KIND_SEARCH;
        endcase
    endfunction

    function automatic logic [31:0] pick_value(logic [1:0] k);
        int r;
        r = $urandom_range(0, 99);
        if (k != KIND_INSERT && table_count > 0 && r < 80)
            return table_mem[$urandom_range(0, table_count - 1)];
        r = $urandom_range(0, 99);
        if (r < 45)
            return 32'($urandom_range(0, 15));
        if (r < 65)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h0000_0000;
                1:       return 32'hFFFF_FFFF;
                2:       return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_request(logic [1:0] k, logic [31:0] v, logic known,
                                table_result_t typed);
        table_result_t predicted;
        in_valid   <= 1'b1;
        kind       <= k;
        item_value <= v;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predicted = apply_table_request(k, v);
        pending_results.push_back(known ? typed : predicted);
        accepted_items++;
        if (!calm && $urandom_range(0, 99) < 8)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d total %0d",
                         $time, status, entry_total);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, status);
                    error_count++;
                end
                if (entry_total !== want.total)
                begin
                    $display("%0t: entry_total mismatch, expected %0d, actual %0d",
                             $time, want.total, entry_total);
                    error_count++;
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!hold_done && accepted_items >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(0, 99) < 8);
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int          real_items;
        int          mode;
        bit          paused;
        logic [1:0]  k;
        logic [31:0] v;

        directed_rows = '{
            '{KIND_SEARCH, 32'h0000_0000, 1'b1, STAT_ABSENT, 6'd0},
            '{KIND_DELETE, 32'h0000_0000, 1'b1, STAT_EMPTY,  6'd0},
            '{KIND_UNUSED, 32'hFFFF_FFFF, 1'b1, STAT_OK,     6'd0},
            '{KIND_INSERT, 32'hFFFF_FFFF, 1'b1, STAT_OK,     6'd1},
            '{KIND_INSERT, 32'h0000_0000, 1'b1, STAT_OK,     6'd2},
            '{KIND_INSERT, 32'h0000_0000, 1'b1, STAT_OK,     6'd3},
            '{KIND_INSERT, 32'h8000_0000, 1'b1, STAT_OK,     6'd4},
            '{KIND_INSERT, 32'h7FFF_FFFF, 1'b1, STAT_OK,     6'd5},
            '{KIND_INSERT, 32'h0000_0001, 1'b0, STAT_OK,     6'd0},
            '{KIND_SEARCH, 32'hFFFF_FFFF, 1'b1, STAT_OK,     6'd6},
            '{KIND_SEARCH, 32'h0000_0000, 1'b1, STAT_OK,     6'd6},
            '{KIND_SEARCH, 32'h7FFF_FFFE, 1'b1, STAT_ABSENT, 6'd6},
            '{KIND_DELETE, 32'h1234_5678, 1'b1, STAT_ABSENT, 6'd6},
            '{KIND_DELETE, 32'h0000_0000, 1'b1, STAT_OK,     6'd5},
            '{KIND_SEARCH, 32'h0000_0000, 1'b0, STAT_OK,     6'd0},
            '{KIND_DELETE, 32'h0000_0000, 1'b0, STAT_OK,     6'd0},
            '{KIND_SEARCH, 32'h0000_0000, 1'b1, STAT_ABSENT, 6'd4},
            '{KIND_UNUSED, 32'h5555_5555, 1'b1, STAT_OK,     6'd4},
            '{KIND_INSERT, 32'hAAAA_AAAA, 1'b0, STAT_OK,     6'd0},
            '{KIND_DELETE, 32'hFFFF_FFFF, 1'b0, STAT_OK,     6'd0},
            '{KIND_DELETE, 32'h8000_0000, 1'b0, STAT_OK,     6'd0},
            '{KIND_DELETE, 32'h0000_0001, 1'b0, STAT_OK,     6'd0},
            '{KIND_DELETE, 32'h7FFF_FFFF, 1'b0, STAT_OK,     6'd0},
            '{KIND_DELETE, 32'hAAAA_AAAA, 1'b1, STAT_OK,     6'd0},
            '{KIND_DELETE, 32'hAAAA_AAAA, 1'b1, STAT_EMPTY,  6'd0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].known,
                         '{directed_rows[i].status, directed_rows[i].total});
        wait_for_results();

        real_items = 0;
        paused = 1'b0;
        while (real_items < RANDOM_ITEMS)
        begin
            calm = (real_items >= 150 && real_items < 230);
            if (real_items == 250 && !paused)
            begin
                wait_for_results();
                paused = 1'b1;
            end
            mode = (real_items / 50) % 4;
            k = pick_kind(mode);
            v = pick_value(k);
            send_request(k, v, 1'b0, '0);
            if (k != KIND_UNUSED)
                real_items++;
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/stid_pkg.sv
hdl/stid_datapath.sv
hdl/stid_ctrl.sv
hdl/sorted_table_insert_delete_search_core.sv
tb/sv/testbench.sv
